// ===== src/sha1bs_pkg.sv =====
package sha1bs_pkg;

    // Classified request kinds; requests with neither byte nor end are dropped at the front
    typedef enum logic [1:0] {
        KIND_BYTE     = 2'b01,
        KIND_END      = 2'b10,
        KIND_BYTE_END = 2'b11
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
    } cmd_t;

    // Control from the sequencer to the compression engine
    typedef struct packed {
        logic start;
        logic load_init;
    } eng_ctrl_t;

    typedef struct packed {
        logic busy;
    } eng_status_t;

    localparam int BLOCK_BYTES  = 64;
    localparam int BLOCK_BITS   = 512;
    localparam int DIGEST_WORDS = 5;
    localparam int ROUNDS       = 80;
    localparam int LEN_OFFSET   = 56;

    localparam logic [159:0] SHA1_IV = {
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_00_19 = 32'h5A827999;
    localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

// ===== src/sha1bs_front.sv =====
module sha1bs_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         data_byte,
    input  logic               byte_present,
    input  logic               end_of_message,
    input  logic               push,
    output logic               full,
    output sha1bs_pkg::cmd_t   cmd,
    output logic               cmd_valid,
    input  logic               cmd_take
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    sha1bs_pkg::cmd_t queue_mem [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    sha1bs_pkg::cmd_t in_cmd;
    logic             keep;
    logic             wr_en;
    logic             rd_en;

    // Classify the incoming request
    always_comb
    begin
        keep        = byte_present | end_of_message;
        in_cmd.data = data_byte;
        if (byte_present && end_of_message)
            in_cmd.kind = sha1bs_pkg::KIND_BYTE_END;
        else if (byte_present)
            in_cmd.kind = sha1bs_pkg::KIND_BYTE;
        else
            in_cmd.kind = sha1bs_pkg::KIND_END;
    end

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_mem[rd_ptr_reg];
    assign wr_en     = push & ~full & keep;
    assign rd_en     = cmd_take & cmd_valid;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            queue_mem[wr_ptr_reg] <= in_cmd;
    end

endmodule

// ===== src/sha1bs_engine.sv =====
module sha1bs_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sha1bs_pkg::eng_ctrl_t        ctrl,
    output sha1bs_pkg::eng_status_t      status,
    input  logic [sha1bs_pkg::BLOCK_BITS-1:0] block,
    output logic [159:0]                 chain
);

    logic [159:0] chain_reg;
    logic [31:0]  win_reg [16];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]   round_reg;
    logic         busy_reg;
    logic [31:0]  f_val;
    logic [31:0]  k_val;
    logic [31:0]  w_new;
    logic [31:0]  w_mix;
    logic [31:0]  t_sum;

    assign chain       = chain_reg;
    assign status.busy = busy_reg;

    // Round function and constant by round range
    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1bs_pkg::K_00_19;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1bs_pkg::K_20_39;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1bs_pkg::K_40_59;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1bs_pkg::K_60_79;
        end
        w_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        w_new = {w_mix[30:0], w_mix[31]};
        t_sum = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + win_reg[0] + k_val;
    end

    // Control: round counter and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg  <= 1'b1;
            round_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (round_reg == 7'(sha1bs_pkg::ROUNDS))
                busy_reg <= 1'b0;
            else
                round_reg <= round_reg + 1'b1;
        end
    end

    // Chaining value: feed-forward add after the last round
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chain_reg <= sha1bs_pkg::SHA1_IV;
        else if (ctrl.load_init)
            chain_reg <= sha1bs_pkg::SHA1_IV;
        else if (busy_reg && round_reg == 7'(sha1bs_pkg::ROUNDS))
        begin
            chain_reg[159:128] <= chain_reg[159:128] + a_reg;
            chain_reg[127:96]  <= chain_reg[127:96]  + b_reg;
            chain_reg[95:64]   <= chain_reg[95:64]   + c_reg;
            chain_reg[63:32]   <= chain_reg[63:32]   + d_reg;
            chain_reg[31:0]    <= chain_reg[31:0]    + e_reg;
        end
    end

    // Working variables and rolling schedule window
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            for (int j = 0; j < 16; j++)
                win_reg[j] <= block[sha1bs_pkg::BLOCK_BITS - 1 - 32 * j -: 32];
            a_reg <= chain_reg[159:128];
            b_reg <= chain_reg[127:96];
            c_reg <= chain_reg[95:64];
            d_reg <= chain_reg[63:32];
            e_reg <= chain_reg[31:0];
        end
        else if (busy_reg && round_reg != 7'(sha1bs_pkg::ROUNDS))
        begin
            for (int j = 0; j < 15; j++)
                win_reg[j] <= win_reg[j + 1];
            win_reg[15] <= w_new;
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t_sum;
        end
    end

endmodule

// ===== src/sha1bs_back.sv =====
module sha1bs_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sha1bs_pkg::cmd_t             cmd,
    input  logic                         cmd_valid,
    output logic                         cmd_take,
    output sha1bs_pkg::eng_ctrl_t        ctrl,
    input  sha1bs_pkg::eng_status_t      status,
    input  logic [159:0]                 chain,
    output logic [sha1bs_pkg::BLOCK_BITS-1:0] block,
    output logic [31:0]                  digest_word,
    output logic [2:0]                   word_index,
    output logic                         last_word,
    output logic                         empty,
    input  logic                         pop
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_ZERO = 5'b00100,
        S_LEN  = 5'b01000,
        S_WAIT = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [sha1bs_pkg::BLOCK_BITS-1:0] block_reg;
    logic [5:0]  fill_reg;
    logic        full_reg;
    logic [63:0] bit_len_reg;
    logic [2:0]  len_idx_reg;
    logic [31:0] hold_reg [sha1bs_pkg::DIGEST_WORDS];
    logic        hold_valid_reg;
    logic [2:0]  out_idx_reg;
    logic        append_en;
    logic [7:0]  append_byte;
    logic        count_en;
    logic        len_step;
    logic        digest_load;
    logic [2:0]  len_sel;
    logic [7:0]  len_byte;
    logic        out_take;

    assign block    = block_reg;
    assign len_sel  = 3'd7 - len_idx_reg;
    assign len_byte = bit_len_reg[{len_sel, 3'b000} +: 8];

    // Start a compression once a block is complete and the engine is free
    assign ctrl.start     = full_reg & ~status.busy;
    assign ctrl.load_init = digest_load;

    // Padding sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_take    = 1'b0;
        append_en   = 1'b0;
        append_byte = cmd.data;
        count_en    = 1'b0;
        len_step    = 1'b0;
        digest_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !full_reg)
                begin
                    cmd_take = 1'b1;
                    unique case (cmd.kind)
                        sha1bs_pkg::KIND_BYTE:
                        begin
                            append_en = 1'b1;
                            count_en  = 1'b1;
                        end
                        sha1bs_pkg::KIND_BYTE_END:
                        begin
                            append_en  = 1'b1;
                            count_en   = 1'b1;
                            state_next = S_PAD;
                        end
                        sha1bs_pkg::KIND_END:
                            state_next = S_PAD;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_PAD:
            begin
                if (!full_reg)
                begin
                    append_en   = 1'b1;
                    append_byte = sha1bs_pkg::PAD_MARK;
                    state_next  = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (!full_reg)
                begin
                    if (fill_reg == 6'(sha1bs_pkg::LEN_OFFSET))
                        state_next = S_LEN;
                    else
                    begin
                        append_en   = 1'b1;
                        append_byte = 8'h00;
                    end
                end
            end
            S_LEN:
            begin
                if (!full_reg)
                begin
                    append_en   = 1'b1;
                    append_byte = len_byte;
                    len_step    = 1'b1;
                    if (len_idx_reg == 3'd7)
                        state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!full_reg && !status.busy && !hold_valid_reg)
                begin
                    digest_load = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            len_idx_reg <= '0;
            bit_len_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (len_step)
                len_idx_reg <= len_idx_reg + 1'b1;
            if (digest_load)
                bit_len_reg <= '0;
            else if (count_en)
                bit_len_reg <= bit_len_reg + 64'd8;
        end
    end

    // Block collector: bytes shift in, first byte ends up in the top lane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            full_reg <= 1'b0;
        end
        else if (append_en)
        begin
            fill_reg <= fill_reg + 1'b1;
            if (fill_reg == 6'(sha1bs_pkg::BLOCK_BYTES - 1))
                full_reg <= 1'b1;
        end
        else if (ctrl.start)
            full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (append_en)
            block_reg <= {block_reg[sha1bs_pkg::BLOCK_BITS-9:0], append_byte};
    end

    // Digest hold: words leave h0 first
    assign out_take    = pop & hold_valid_reg;
    assign empty       = ~hold_valid_reg;
    assign digest_word = hold_reg[0];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'(sha1bs_pkg::DIGEST_WORDS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_idx_reg    <= '0;
        end
        else if (digest_load)
        begin
            hold_valid_reg <= 1'b1;
            out_idx_reg    <= '0;
        end
        else if (out_take)
        begin
            if (last_word)
            begin
                hold_valid_reg <= 1'b0;
                out_idx_reg    <= '0;
            end
            else
                out_idx_reg <= out_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (digest_load)
        begin
            for (int i = 0; i < sha1bs_pkg::DIGEST_WORDS; i++)
                hold_reg[i] <= chain[159 - 32 * i -: 32];
        end
        else if (out_take)
        begin
            for (int i = 0; i < sha1bs_pkg::DIGEST_WORDS - 1; i++)
                hold_reg[i] <= hold_reg[i + 1];
        end
    end

endmodule

// ===== src/sha1_byte_stream_hasher_unit.sv =====
// SHA-1 hasher for a byte stream.
// Input queue: drive data_byte, byte_present and end_of_message with push; a
// request is taken on a clock edge with push high and full low. A request with
// end_of_message set (with or without a byte) closes the message.
// Result queue: while empty is low, digest_word/word_index/last_word show the
// oldest digest word; pop takes it. Five words per message, h0 first.
// Throughput: one byte per cycle into the block collector, except while a
// message is being padded or a full block waits for the round engine; each
// 64-byte block takes 80 rounds plus the feed-forward add in the round engine,
// overlapped with collecting the next block. Closing a message runs one final
// compression before the first digest word, or two when the padding spills
// into a second block, and first waits for the engine if it is still busy
// with the previous full block.
// Reset clears the queues and loads the initial chaining value; no clearing
// pass. If the receiver stalls, the digest is held and the next message keeps
// hashing; a further digest waits until the held one is fully popped.
module sha1_byte_stream_hasher_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    input  logic        push,
    output logic        full,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        empty,
    input  logic        pop
);

    sha1bs_pkg::cmd_t          cmd;
    logic                      cmd_valid;
    logic                      cmd_take;
    sha1bs_pkg::eng_ctrl_t     eng_ctrl;
    sha1bs_pkg::eng_status_t   eng_status;
    logic [159:0]              chain;
    logic [sha1bs_pkg::BLOCK_BITS-1:0] block;

    sha1bs_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .cmd_valid      (cmd_valid),
        .cmd_take       (cmd_take)
    );

    sha1bs_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (eng_ctrl),
        .status (eng_status),
        .block  (block),
        .chain  (chain)
    );

    sha1bs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid),
        .cmd_take    (cmd_take),
        .ctrl        (eng_ctrl),
        .status      (eng_status),
        .chain       (chain),
        .block       (block),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // Limits and fixed digests
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 300;
    localparam logic [159:0] EMPTY_DIGEST =
        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] ABC_DIGEST   =
        160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;
    localparam logic [159:0] NO_DIGEST    = '0;
    localparam logic [7:0]  PAD_BYTE      = 8'h80;

    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         eom;
        logic         typed;
        logic [159:0] digest;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        is_last;
    } digest_word_t;

    logic        clk;
    logic        rst_n;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        end_of_message;
    logic        push;
    logic        full;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        empty;
    logic        pop;

    // Hash model state
    logic [31:0] chain_h [5];
    logic [7:0]  msg_block [64];
    logic [63:0] msg_bits;

    digest_word_t pending_digest_words [$];

    int  mismatches;
    int  requests_sent;
    int  random_bytes;
    int  messages_closed;
    int  words_checked;
    int  cycles;
    bit  steady_phase;

    // Directed requests; typed digests only for the textbook messages
    stim_row_t directed_reqs [17] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h63, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'hff, 1'b0, 1'b1, 1'b1, ABC_DIGEST},
        '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        '{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        '{8'h55, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'haa, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        '{8'h0f, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'h80, 1'b1, 1'b1, 1'b0, NO_DIGEST}
    };

    // Message lengths around the padding boundary: exact fit and spill
    int pad_lengths [2] = '{55, 63};

    sha1_byte_stream_hasher_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .push           (push),
        .full           (full),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .empty          (empty),
        .pop            (pop)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic sha1_restart();
        chain_h[0] = 32'h67452301;
        chain_h[1] = 32'hEFCDAB89;
        chain_h[2] = 32'h98BADCFE;
        chain_h[3] = 32'h10325476;
        chain_h[4] = 32'hC3D2E1F0;
        msg_bits   = '0;
    endtask

    // 80-round compression of msg_block into chain_h
    task automatic sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < 80; t++)
        begin
            if (t >= 16)
                w[t % 16] = rol32(w[(t - 3) % 16] ^ w[(t - 8) % 16] ^
                                  w[(t - 14) % 16] ^ w[t % 16], 1);
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            tmp = rol32(a, 5) + f + e + w[t % 16] + k;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = tmp;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    // Absorb one accepted request; on end of message queue the five digest words
    task automatic sha1_absorb_request(input logic [7:0] d, input logic bp, input logic eom,
                                       input logic typed, input logic [159:0] typed_digest);
        int           fill;
        logic [63:0]  len;
        logic [159:0] dg;
        if (bp)
        begin
            fill = int'(msg_bits[8:3]);
            msg_block[fill] = d;
            msg_bits += 64'd8;
            if (fill == 63)
                sha1_compress();
        end
        if (eom)
        begin
            fill = int'(msg_bits[8:3]);
            len  = msg_bits;
            msg_block[fill] = PAD_BYTE;
            fill++;
            // no room for the length: pad out and spill into a second block
            if (fill > 56)
            begin
                while (fill < 64)
                begin
                    msg_block[fill] = 8'h00;
                    fill++;
                end
                sha1_compress();
                fill = 0;
            end
            while (fill < 56)
            begin
                msg_block[fill] = 8'h00;
                fill++;
            end
            for (int i = 0; i < 8; i++)
                msg_block[56 + i] = len[63 - 8*i -: 8];
            sha1_compress();
            dg = typed ? typed_digest
                       : {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
            for (int i = 0; i < 5; i++)
                pending_digest_words.push_back('{dg[159 - 32*i -: 32], 3'(i), i == 4});
            sha1_restart();
            messages_closed++;
        end
    endtask

    // Drive one request and hold it until the block takes it
    task automatic send_request(input logic [7:0] d, input logic bp, input logic eom,
                                input logic typed, input logic [159:0] typed_digest);
        int gap;
        gap = 0;
        if (!steady_phase)
            while ($urandom_range(99) < 20)
                gap++;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push           <= 1'b1;
        data_byte      <= d;
        byte_present   <= bp;
        end_of_message <= eom;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sha1_absorb_request(d, bp, eom, typed, typed_digest);
        requests_sent++;
    endtask

    // Random message; the last byte sometimes rides on the end request
    task automatic send_message(input int nbytes);
        bit end_with_byte;
        end_with_byte = (nbytes > 0) && ($urandom_range(1) == 1);
        for (int i = 0; i < nbytes - int'(end_with_byte); i++)
        begin
            // occasional empty request in the middle of a message
            if ($urandom_range(9) == 0)
                send_request(8'($urandom), 1'b0, 1'b0, 1'b0, NO_DIGEST);
            send_request(8'($urandom), 1'b1, 1'b0, 1'b0, NO_DIGEST);
            random_bytes++;
        end
        send_request(8'($urandom), end_with_byte, 1'b1, 1'b0, NO_DIGEST);
        random_bytes += int'(end_with_byte);
    endtask

    // Stop sending until every outstanding digest word has been popped
    task automatic hold_until_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending_digest_words.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        int msg_no;
        int pad_pick;
        int len;
        rst_n          = 1'b0;
        push           = 1'b0;
        data_byte      = 8'h00;
        byte_present   = 1'b0;
        end_of_message = 1'b0;
        steady_phase   = 1'b0;
        mismatches     = 0;
        requests_sent  = 0;
        random_bytes   = 0;
        messages_closed = 0;
        words_checked  = 0;
        sha1_restart();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_reqs[i])
            send_request(directed_reqs[i].data, directed_reqs[i].present,
                         directed_reqs[i].eom, directed_reqs[i].typed,
                         directed_reqs[i].digest);
        hold_until_drained();

        msg_no   = 0;
        pad_pick = 0;
        while (requests_sent < 180 || pad_pick < 2)
        begin
            steady_phase <= (msg_no >= 3 && msg_no < 6);
            if (msg_no % 3 == 1 && pad_pick < 2)
            begin
                len = pad_lengths[pad_pick];
                pad_pick++;
            end
            else
                len = $urandom_range(12);
            send_message(len);
            if (msg_no == 7)
                hold_until_drained();
            msg_no++;
        end
        steady_phase <= 1'b0;

        // drain, then watch for stray words
        push <= 1'b0;
        @(posedge clk);
        while (pending_digest_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d requests (%0d random bytes) over %0d messages, %0d words,",
                 requests_sent, random_bytes, messages_closed, words_checked);
        $display("with empty messages, byte-with-end closes and 55/63-byte lengths.");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Result side: pop at random (always in steady_phase); check vs oldest expectation
    initial
    begin
        digest_word_t exp_w;
        pop = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_digest_words.size() == 0)
                begin
                    $display("%0t: unexpected digest word %h index %0d last %b",
                             $time, digest_word, word_index, last_word);
                    mismatches++;
                end
                else
                begin
                    exp_w = pending_digest_words.pop_front();
                    words_checked++;
                    if (digest_word !== exp_w.word || word_index !== exp_w.index ||
                        last_word !== exp_w.is_last)
                    begin
                        $display("%0t: expected %h/%0d/%b, got %h/%0d/%b", $time,
                                 exp_w.word, exp_w.index, exp_w.is_last,
                                 digest_word, word_index, last_word);
                        mismatches++;
                    end
                end
            end
            pop <= steady_phase || ($urandom_range(99) >= 20);
        end
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d digest words outstanding",
                 cycles, pending_digest_words.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sha1bs_pkg.sv
src/sha1bs_front.sv
src/sha1bs_engine.sv
src/sha1bs_back.sv
src/sha1_byte_stream_hasher_unit.sv
dv/tb.sv
